// ----- hdl/spp_pkg.sv -----
// Package: shared constants and types of the sweep-and-prune pair finder.
`timescale 1ns / 1ps

package spp_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 32;
    localparam int FIELD_BITS     = 32;
    localparam int IDX_BITS       = 6;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;

    // Register indexes, taken from paddr[2]
    localparam logic REG_AXIS_SEL  = 1'b0;
    localparam logic REG_TWO_LISTS = 1'b1;

    // Sweep axis codes; the unused code acts as z
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic STATUS_PAIR = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0] axis_sel;
        logic       two_lists;
    } spp_cfg_t;

endpackage

// ----- hdl/spp_if.sv -----
// Interfaces: box input channel and pair result channel.
`timescale 1ns / 1ps

interface spp_box_if;
    import spp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  set_start;
    logic                  in_list_a;
    logic [FIELD_BITS-1:0] low_x;
    logic [FIELD_BITS-1:0] low_y;
    logic [FIELD_BITS-1:0] low_z;
    logic [FIELD_BITS-1:0] high_x;
    logic [FIELD_BITS-1:0] high_y;
    logic [FIELD_BITS-1:0] high_z;

    modport source (output valid, set_start, in_list_a, low_x, low_y, low_z,
                    high_x, high_y, high_z, input ready);
    modport sink (input valid, set_start, in_list_a, low_x, low_y, low_z,
                  high_x, high_y, high_z, output ready);
endinterface

interface spp_pair_if;
    import spp_pkg::*;
    logic                valid;
    logic                ready;
    logic [IDX_BITS-1:0] earlier_index;
    logic [IDX_BITS-1:0] later_index;
    logic                status;
    logic                last_of_run;

    modport source (output valid, earlier_index, later_index, status, last_of_run,
                    input ready);
    modport sink (input valid, earlier_index, later_index, status, last_of_run,
                  output ready);
endinterface

// ----- hdl/spp_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module spp_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data while no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/spp_cfg.sv -----
// APB register file: sweep axis and two-list mode.
`timescale 1ns / 1ps

module spp_cfg
    import spp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output spp_cfg_t                 cfg
);

    logic [1:0] axis_sel_reg;
    logic       two_lists_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_sel_reg  <= AXIS_X;
            two_lists_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_AXIS_SEL:  axis_sel_reg  <= pwdata[1:0];
                REG_TWO_LISTS: two_lists_reg <= pwdata[0];
                default:       two_lists_reg <= two_lists_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_AXIS_SEL:  prdata = {{(APB_DATA_BITS-2){1'b0}}, axis_sel_reg};
            REG_TWO_LISTS: prdata = {{(APB_DATA_BITS-1){1'b0}}, two_lists_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg = '{axis_sel: axis_sel_reg, two_lists: two_lists_reg};

endmodule

// ----- hdl/spp_sweep.sv -----
// Sweep engine: stores box keys in RAM and scans them for each new box.
`timescale 1ns / 1ps

module spp_sweep
    import spp_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF,
    parameter int KEY_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                two_lists,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                set_start,
    input  logic                tag,
    input  logic [KEY_BITS-1:0] low_key,
    input  logic [KEY_BITS-1:0] high_key,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_BITS-1:0] earlier_index,
    output logic [IDX_BITS-1:0] later_index,
    output logic                status,
    output logic                last_of_run
);

    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int DW = KEY_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SWEEP  = 4'b0010,
        S_FINISH = 4'b0100,
        S_FULL   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       later_reg, later_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic [KEY_BITS-1:0] low_key_reg, low_key_next;
    logic                tag_reg, tag_next;
    logic                out_valid_reg, out_valid_next;
    logic [AW-1:0]       out_earlier_reg, out_earlier_next;
    logic [AW-1:0]       out_later_reg, out_later_next;
    logic                out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [DW-1:0]       ram_wdata, ram_rdata;
    logic [CW-1:0]       k_cur;
    logic                full;
    logic                out_free, hit, consume, issue;

    spp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign k_cur    = set_start ? '0 : count_reg;
    assign full     = (k_cur >= CW'(MAX_BOXES));
    assign out_free = !out_valid_reg || out_ready;
    assign hit      = cmp_valid_reg && (ram_rdata[KEY_BITS-1:0] >= low_key_reg)
                      && (!two_lists || (ram_rdata[KEY_BITS] != tag_reg));
    assign consume  = cmp_valid_reg && (!hit || !pend_valid_reg || out_free);
    assign issue    = (rd_ptr_reg != later_reg) && (!cmp_valid_reg || consume);

    assign ram_waddr = k_cur[AW-1:0];
    assign ram_wdata = {tag, high_key};
    assign ram_raddr = rd_ptr_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        later_next       = later_reg;
        rd_ptr_next      = rd_ptr_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        low_key_next     = low_key_reg;
        tag_next         = tag_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_earlier_next = out_earlier_reg;
        out_later_next   = out_later_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        in_ready         = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (full)
                    begin
                        state_next = S_FULL;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        count_next      = CW'(k_cur + 1'b1);
                        later_next      = k_cur[AW-1:0];
                        low_key_next    = low_key;
                        tag_next        = tag;
                        rd_ptr_next     = '0;
                        cmp_valid_next  = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = (k_cur == '0) ? S_IDLE : S_SWEEP;
                    end
                end
            end
            S_FULL:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_earlier_next = '0;
                    out_later_next   = '0;
                    out_status_next  = STATUS_FULL;
                    out_last_next    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                // a new hit pushes the held one out; the newest stays held
                if (consume && hit)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next   = 1'b1;
                        out_earlier_next = pend_idx_reg;
                        out_later_next   = later_reg;
                        out_status_next  = STATUS_PAIR;
                        out_last_next    = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = cmp_idx_reg;
                end
                if (issue)
                begin
                    ram_re         = 1'b1;
                    rd_ptr_next    = AW'(rd_ptr_reg + 1'b1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_ptr_reg;
                end
                else if (consume)
                begin
                    cmp_valid_next = 1'b0;
                end
                if (!issue && (consume || !cmp_valid_reg) && (rd_ptr_reg == later_reg))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_earlier_next = pend_idx_reg;
                    out_later_next   = later_reg;
                    out_status_next  = STATUS_PAIR;
                    out_last_next    = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_ptr_reg     <= rd_ptr_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        later_reg       <= later_next;
        cmp_idx_reg     <= cmp_idx_next;
        pend_idx_reg    <= pend_idx_next;
        low_key_reg     <= low_key_next;
        tag_reg         <= tag_next;
        out_earlier_reg <= out_earlier_next;
        out_later_reg   <= out_later_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign earlier_index = IDX_BITS'(out_earlier_reg);
    assign later_index   = IDX_BITS'(out_later_reg);
    assign status        = out_status_reg;
    assign last_of_run   = out_last_reg;

endmodule

// ----- hdl/sweep_and_prune_pair_finder.sv -----
// Top level: sweep-and-prune broad-phase pair finder.
`timescale 1ns / 1ps

// Boxes arrive on the box channel already sorted by their low bound on the
// axis chosen by the axis select register; set_start begins a new set and makes
// the box index zero. Each box's high bound on that axis and its list tag go
// into one store RAM, and the new box is then compared against every earlier
// box of the set, one stored entry per cycle through the single read port of
// that RAM while the pair channel does not stall. A box with k earlier boxes
// takes k reads plus pipeline fill and the closing result, longer while the
// pair channel stalls; a first box of a set needs no reads. Pairs come out
// grouped by the later box with the earlier index ascending, and the final
// pair of a box carries last_of_run. A box refused for a full store gives one
// transaction with status set. The pair output is registered, so a new box
// is taken while the last result of the previous one still waits. No clearing
// pass runs after reset: entries are only read below the current box count.
// Write the configuration registers only while the block is idle.

module sweep_and_prune_pair_finder
    import spp_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    spp_box_if.sink                  box,
    spp_pair_if.source               pair,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    // compare width: coordinates are signed values of at most one field width
    localparam int KEY_BITS = (COORD_BITS >= FIELD_BITS) ? FIELD_BITS : COORD_BITS;

    spp_cfg_t              cfg;
    logic [FIELD_BITS-1:0] low_raw, high_raw;
    logic [KEY_BITS-1:0]   low_key, high_key;

    spp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Select the sweep axis; the unused code acts as z
    always_comb
    begin
        unique case (cfg.axis_sel)
            AXIS_X:
            begin
                low_raw  = box.low_x;
                high_raw = box.high_x;
            end
            AXIS_Y:
            begin
                low_raw  = box.low_y;
                high_raw = box.high_y;
            end
            default:
            begin
                low_raw  = box.low_z;
                high_raw = box.high_z;
            end
        endcase
    end

    // Flip the sign bit so an unsigned compare orders signed coordinates
    assign low_key  = {~low_raw[KEY_BITS-1], low_raw[KEY_BITS-2:0]};
    assign high_key = {~high_raw[KEY_BITS-1], high_raw[KEY_BITS-2:0]};

    spp_sweep #(
        .MAX_BOXES (MAX_BOXES),
        .KEY_BITS  (KEY_BITS)
    ) u_sweep (
        .clk           (clk),
        .rst_n         (rst_n),
        .two_lists     (cfg.two_lists),
        .in_valid      (box.valid),
        .in_ready      (box.ready),
        .set_start     (box.set_start),
        .tag           (box.in_list_a),
        .low_key       (low_key),
        .high_key      (high_key),
        .out_valid     (pair.valid),
        .out_ready     (pair.ready),
        .earlier_index (pair.earlier_index),
        .later_index   (pair.later_index),
        .status        (pair.status),
        .last_of_run   (pair.last_of_run)
    );

endmodule

// ----- hdl/spp_checker.sv -----
// Checker: port-level assertions for the pair finder, bound to the top level.
`timescale 1ns / 1ps

module spp_checker
    import spp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                pair_valid,
    input logic                pair_ready,
    input logic [IDX_BITS-1:0] earlier_index,
    input logic [IDX_BITS-1:0] later_index,
    input logic                status,
    input logic                last_of_run
);

    // Hold a stalled pair transaction unchanged
    a_pair_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && !pair_ready |=> pair_valid
            && $stable({earlier_index, later_index, status, last_of_run}))
        else $error("pair transaction changed while stalled");

    // A full-store drop is a single closing transaction at index zero
    a_full_form: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && (status == STATUS_FULL) |-> last_of_run
            && (earlier_index == '0) && (later_index == '0))
        else $error("malformed store-full transaction");

    // A candidate pair always names an earlier box
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && (status == STATUS_PAIR) |-> earlier_index < later_index)
        else $error("earlier index not below later index");

    // Keep one run together: after a non-closing pair comes the same later box
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && pair_ready && !last_of_run |=> !pair_valid
            || ((later_index == $past(later_index)) && (status == STATUS_PAIR)
                && (earlier_index > $past(earlier_index))))
        else $error("run of pairs broken before its closing transaction");

endmodule

bind sweep_and_prune_pair_finder spp_checker u_spp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pair_valid    (pair.valid),
    .pair_ready    (pair.ready),
    .earlier_index (pair.earlier_index),
    .later_index   (pair.later_index),
    .status        (pair.status),
    .last_of_run   (pair.last_of_run)
);
